// ----- rtl/complex_arithmetic_unit_macros.svh -----
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTH
`define CAU_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define CAU_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CAU_ASSERT_IMP(lbl, pre, post, msg)
`define CAU_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/cau_pkg.sv -----
// Shared constants, types and helpers of the complex arithmetic unit
package cau_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW   = 16;
  localparam int OPW  = 3;
  localparam int STW  = 2;
  localparam int PW   = 2 * DW;
  localparam int SUMW = PW + 1;
  localparam int DIRW = SUMW;
  localparam int MAGW = PW;
  localparam int DENW = PW;
  localparam int NUMW = MAGW + FRAC_BITS;
  localparam int QW   = DW + 2;
  localparam int CMPW = (NUMW > DENW + QW) ? NUMW : DENW + QW;
  localparam int NSQ  = DW;
  localparam int SQW  = 2 * DW;
  localparam int NITER = QW;
  localparam int IDXW = $clog2(NITER);

  localparam logic [OPW-1:0] OP_ADD  = 3'd0;
  localparam logic [OPW-1:0] OP_SUB  = 3'd1;
  localparam logic [OPW-1:0] OP_MUL  = 3'd2;
  localparam logic [OPW-1:0] OP_DIV  = 3'd3;
  localparam logic [OPW-1:0] OP_CONJ = 3'd4;
  localparam logic [OPW-1:0] OP_MOD  = 3'd5;

  localparam logic [STW-1:0] ST_OK      = 2'd0;
  localparam logic [STW-1:0] ST_SAT     = 2'd1;
  localparam logic [STW-1:0] ST_DIVZERO = 2'd2;

  localparam logic signed [DW-1:0] RES_MAX = DW'((2 ** (DW - 1)) - 1);
  localparam logic signed [DW-1:0] RES_MIN = -RES_MAX - DW'(1);

  // one word in flight through the divide / root steps
  typedef struct packed {
    logic [OPW-1:0]         op;
    logic signed [DIRW-1:0] direct_re;
    logic signed [DIRW-1:0] direct_im;
    logic                   den_zero;
    logic [DENW-1:0]        den;
    logic [NUMW-1:0]        rem_re;
    logic [NUMW-1:0]        rem_im;
    logic                   neg_re;
    logic                   neg_im;
    logic [QW-1:0]          q_re;
    logic [QW-1:0]          q_im;
    logic [SQW-1:0]         sq_v;
    logic [SQW-1:0]         sq_root;
  } item_t;

  // clamp to the result range; top bit flags saturation
  function automatic logic [DW:0] clamp_res(input logic signed [DIRW-1:0] v);
    logic signed [DIRW-1:0] hi;
    logic signed [DIRW-1:0] lo;
    hi = DIRW'(RES_MAX);
    lo = DIRW'(RES_MIN);
    if (v > hi) begin
      clamp_res = {1'b1, RES_MAX};
    end else if (v < lo) begin
      clamp_res = {1'b1, RES_MIN};
    end else begin
      clamp_res = {1'b0, v[DW-1:0]};
    end
  endfunction

endpackage

// ----- rtl/complex_arithmetic_unit.sv -----
// Top level: complex-number ALU, Q8.8 operands, pipelined divide and root.
// Stages: 3 front stages, 18 divide/root bit stages and 1 output register.
// Throughput: one word per cycle while out_stall is low; each stage moves when
// the next has room, so bubbles collapse under output stall.
// Reset (synchronous, rst_n low): all stage valid bits clear; data registers are not reset.
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OPW-1:0]        in_op,
  input  logic signed [DW-1:0]  in_a_re,
  input  logic signed [DW-1:0]  in_a_im,
  input  logic signed [DW-1:0]  in_b_re,
  input  logic signed [DW-1:0]  in_b_im,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [DW-1:0]  out_res_re,
  output logic signed [DW-1:0]  out_res_im,
  output logic [STW-1:0]        out_status
);

  localparam int NS = 3 + NITER + 1;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  // stage 0: operand registers
  logic [OPW-1:0]        op0_r;
  logic signed [DW-1:0]  ar0_r, ai0_r, br0_r, bi0_r;

  // stage 1: products and simple results
  logic [OPW-1:0]        op1_r;
  logic signed [DW:0]    smp_re1_r, smp_im1_r;
  logic signed [PW-1:0]  p_rr_r, p_ii_r, p_ri_r, p_ir_r, sx_r, sy_r;
  logic signed [DW:0]    smp_re_nxt, smp_im_nxt;
  logic signed [DW-1:0]  x0, y0;
  logic signed [PW-1:0]  p_rr_nxt, p_ii_nxt, p_ri_nxt, p_ir_nxt, sx_nxt, sy_nxt;

  // stage 2 and step stages
  item_t                 s2_r;
  item_t                 s2_nxt;
  item_t                 it_r   [NITER];
  item_t                 it_nxt [NITER];
  logic signed [SUMW-1:0] mre, mim, nre, nim, dsum;
  logic signed [SUMW-1:0] are, aim;

  // output register
  logic signed [DW-1:0]  res_re_nxt, res_im_nxt;
  logic [STW-1:0]        status_nxt;
  logic signed [DW-1:0]  res_re_r, res_im_r;
  logic [STW-1:0]        status_r;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end
  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 0 load
  always_ff @(posedge clk) begin
    if (en[0]) begin
      op0_r <= in_op;
      ar0_r <= in_a_re;
      ai0_r <= in_a_im;
      br0_r <= in_b_re;
      bi0_r <= in_b_im;
    end
  end

  // multiply and form add / subtract / conjugate
  always_comb begin
    x0 = (op0_r == OP_MOD) ? ar0_r : br0_r;
    y0 = (op0_r == OP_MOD) ? ai0_r : bi0_r;
    p_rr_nxt = ar0_r * br0_r;
    p_ii_nxt = ai0_r * bi0_r;
    p_ri_nxt = ar0_r * bi0_r;
    p_ir_nxt = ai0_r * br0_r;
    sx_nxt   = x0 * x0;
    sy_nxt   = y0 * y0;
    smp_re_nxt = '0;
    smp_im_nxt = '0;
    if (op0_r == OP_ADD) begin
      smp_re_nxt = (DW+1)'(ar0_r) + (DW+1)'(br0_r);
      smp_im_nxt = (DW+1)'(ai0_r) + (DW+1)'(bi0_r);
    end else if (op0_r == OP_SUB) begin
      smp_re_nxt = (DW+1)'(ar0_r) - (DW+1)'(br0_r);
      smp_im_nxt = (DW+1)'(ai0_r) - (DW+1)'(bi0_r);
    end else if (op0_r == OP_CONJ) begin
      smp_re_nxt = (DW+1)'(ar0_r);
      smp_im_nxt = -(DW+1)'(ai0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1_r     <= op0_r;
      smp_re1_r <= smp_re_nxt;
      smp_im1_r <= smp_im_nxt;
      p_rr_r    <= p_rr_nxt;
      p_ii_r    <= p_ii_nxt;
      p_ri_r    <= p_ri_nxt;
      p_ir_r    <= p_ir_nxt;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
    end
  end

  // sums, product scaling toward zero, divider and root setup
  always_comb begin
    mre  = SUMW'(p_rr_r) - SUMW'(p_ii_r);
    mim  = SUMW'(p_ri_r) + SUMW'(p_ir_r);
    nre  = SUMW'(p_rr_r) + SUMW'(p_ii_r);
    nim  = SUMW'(p_ir_r) - SUMW'(p_ri_r);
    dsum = SUMW'(sx_r) + SUMW'(sy_r);
    are  = mre;
    aim  = mim;
    if (mre < 0) are = mre + SUMW'((1 << FRAC_BITS) - 1);
    if (mim < 0) aim = mim + SUMW'((1 << FRAC_BITS) - 1);
    s2_nxt = '0;
    s2_nxt.op = op1_r;
    if (op1_r == OP_MUL) begin
      s2_nxt.direct_re = DIRW'(are >>> FRAC_BITS);
      s2_nxt.direct_im = DIRW'(aim >>> FRAC_BITS);
    end else begin
      s2_nxt.direct_re = DIRW'(smp_re1_r);
      s2_nxt.direct_im = DIRW'(smp_im1_r);
    end
    s2_nxt.den      = dsum[DENW-1:0];
    s2_nxt.den_zero = (dsum[DENW-1:0] == '0);
    s2_nxt.neg_re   = nre < 0;
    s2_nxt.neg_im   = nim < 0;
    s2_nxt.rem_re   = NUMW'($unsigned((nre < 0) ? MAGW'(-nre) : MAGW'(nre))) << FRAC_BITS;
    s2_nxt.rem_im   = NUMW'($unsigned((nim < 0) ? MAGW'(-nim) : MAGW'(nim))) << FRAC_BITS;
    s2_nxt.sq_v     = SQW'(dsum[DENW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) s2_r <= s2_nxt;
  end

  // divide / root bit stages
  for (genvar j = 0; j < NITER; j++) begin : g_step
    cau_step u_step (
      .item_i ((j == 0) ? s2_r : it_r[(j == 0) ? 0 : j - 1]),
      .idx_i  (IDXW'(j)),
      .item_o (it_nxt[j])
    );
    always_ff @(posedge clk) begin
      if (en[3+j]) it_r[j] <= it_nxt[j];
    end
  end

  // final select and saturation
  cau_sat u_sat (
    .item_i   (it_r[NITER-1]),
    .res_re_o (res_re_nxt),
    .res_im_o (res_im_nxt),
    .status_o (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_res_re = res_re_r;
  assign out_res_im = res_im_r;
  assign out_status = status_r;

  `CAU_ASSERT_IMP(a_divz_zero, out_valid && out_status == ST_DIVZERO, out_res_re == '0 && out_res_im == '0, "divide by zero word carries nonzero data")
  `CAU_ASSERT_IMP(a_sat_rail, out_valid && out_status == ST_SAT, out_res_re == RES_MAX || out_res_re == RES_MIN || out_res_im == RES_MAX || out_res_im == RES_MIN, "saturated word has no part at a rail")
  `CAU_ASSERT_IMP(a_empty_ready, !vld_r[0], !in_stall, "input stalled with empty first stage")
  `CAU_ASSERT_NXT(a_accept_loads, in_valid && !in_stall, vld_r[0], "accepted word not captured")

endmodule

// ----- rtl/cau_step.sv -----
// One restoring divide bit per pipeline stage and, while idx_i < NSQ, one square-root digit
module cau_step import cau_pkg::*; (
  input  item_t            item_i,
  input  logic [IDXW-1:0]  idx_i,
  output item_t            item_o
);

  logic [CMPW-1:0] dsh;
  logic [CMPW-1:0] rre;
  logic [CMPW-1:0] rim;
  logic [QW-1:0]   qbit;
  logic [SQW-1:0]  sbit;
  logic [SQW-1:0]  ssum;
  int unsigned     b;
  int unsigned     sb;

  always_comb begin
    item_o = item_i;
    // divide: try the shifted divisor at this quotient bit
    b    = (QW - 1) - int'(idx_i);
    dsh  = CMPW'(item_i.den) << b;
    qbit = QW'(1) << b;
    rre  = CMPW'(item_i.rem_re);
    rim  = CMPW'(item_i.rem_im);
    if (rre >= dsh) begin
      item_o.rem_re = NUMW'(rre - dsh);
      item_o.q_re   = item_i.q_re | qbit;
    end
    if (rim >= dsh) begin
      item_o.rem_im = NUMW'(rim - dsh);
      item_o.q_im   = item_i.q_im | qbit;
    end
    // root: one digit, last stages only pass through
    sb   = 0;
    sbit = '0;
    ssum = '0;
    if (int'(idx_i) < NSQ) begin
      sb   = 2 * (NSQ - 1 - int'(idx_i));
      sbit = SQW'(1) << sb;
      ssum = item_i.sq_root + sbit;
      if (item_i.sq_v >= ssum) begin
        item_o.sq_v    = item_i.sq_v - ssum;
        item_o.sq_root = (item_i.sq_root >> 1) + sbit;
      end else begin
        item_o.sq_root = item_i.sq_root >> 1;
      end
    end
  end

endmodule

// ----- rtl/cau_sat.sv -----
// Result select, sign fixup and saturation
module cau_sat import cau_pkg::*; (
  input  item_t                  item_i,
  output logic signed [DW-1:0]   res_re_o,
  output logic signed [DW-1:0]   res_im_o,
  output logic [STW-1:0]         status_o
);

  logic signed [QW:0]   qs_re;
  logic signed [QW:0]   qs_im;
  logic [DW:0]          c_re;
  logic [DW:0]          c_im;

  always_comb begin
    qs_re = $signed({1'b0, item_i.q_re});
    qs_im = $signed({1'b0, item_i.q_im});
    if (item_i.neg_re) qs_re = -qs_re;
    if (item_i.neg_im) qs_im = -qs_im;
    c_re = '0;
    c_im = '0;
    res_re_o = '0;
    res_im_o = '0;
    status_o = ST_OK;
    unique case (item_i.op)
      OP_ADD, OP_SUB, OP_CONJ, OP_MUL: begin
        c_re = clamp_res(item_i.direct_re);
        c_im = clamp_res(item_i.direct_im);
      end
      OP_DIV: begin
        c_re = clamp_res(DIRW'(qs_re));
        c_im = clamp_res(DIRW'(qs_im));
      end
      OP_MOD: begin
        c_re = clamp_res(DIRW'(item_i.sq_root));
      end
      default: begin
      end
    endcase
    if (item_i.op == OP_DIV && item_i.den_zero) begin
      status_o = ST_DIVZERO;
    end else begin
      res_re_o = c_re[DW-1:0];
      res_im_o = c_im[DW-1:0];
      if (c_re[DW] || c_im[DW]) status_o = ST_SAT;
    end
  end

endmodule
